// ===== src/dsp_pkg.sv =====
// Shared constants, opcodes, controller states and the control/status
// structs for the DAG shortest path block. No dependencies.
package dsp_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int NCNT_W    = NODE_W + 1;
  localparam int EDGE_AW   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = EDGE_AW + 1;
  localparam int WEIGHT_W  = 16;
  localparam int DIST_W    = 22;
  localparam int CFG_W     = 7;
  localparam int EDGE_W    = 2 * NODE_W + WEIGHT_W;
  localparam int STK_W     = NODE_W + ECNT_W;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(MAX_NODES);
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_DREQ,
    S_DCHK,
    S_DPOP,
    S_RK,
    S_RU,
    S_RD,
    S_REQ,
    S_RCHK,
    S_RCMP,
    S_OREQ,
    S_OSEND
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic root_next;
    logic root_start;
    logic edge_rd;
    logic fin_push;
    logic stk_rd;
    logic dfs_step;
    logic stk_load;
    logic relax_start;
    logic fin_rd;
    logic ubest_rd;
    logic du_load;
    logic e_next;
    logic vbest_rd;
    logic relax_upd;
    logic out_start;
    logic obest_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic run_ok;
    logic root_done;
    logic root_visited;
    logic edge_end;
    logic depth_zero;
    logic k_zero;
    logic u_reached;
    logic relax_match;
    logic out_last;
  } status_t;

endpackage

// ===== src/dag_shortest_path.sv =====
// Top level of the DAG shortest path block: controller plus datapath.
// Depends on dsp_pkg, dsp_ctrl, dsp_dp.
//
// Clear and add-edge transactions each deliver one result.
// A run handles one transaction at a time: the depth-first walk scans the
// whole edge store once per visited node with one read of the single edge
// RAM port and one decision per edge, and relaxation rescans it for each
// reached node, adding a distance RAM read for each matching edge.
// A run then delivers N results for N nodes, each held until accepted.
module dag_shortest_path (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dsp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          opcode_i,
  input  logic [dsp_pkg::NODE_W-1:0]          from_node_i,
  input  logic [dsp_pkg::NODE_W-1:0]          to_node_i,
  input  logic signed [dsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  logic [dsp_pkg::NODE_W-1:0]          source_node_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dsp_pkg::NODE_W-1:0]          node_index_o,
  output logic signed [dsp_pkg::DIST_W-1:0]   distance_o,
  output logic                                reachable_o,
  output logic                                status_o,
  output logic                                last_o
);
  import dsp_pkg::*;

  cmd_t    cmd;
  status_t stat;

  assign in_ready_o = cmd.in_ready;

  dsp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  dsp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .opcode_i      (opcode_i),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .edge_weight_i (edge_weight_i),
    .source_node_i (source_node_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .node_index_o  (node_index_o),
    .distance_o    (distance_o),
    .reachable_o   (reachable_o),
    .status_o      (status_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .stat_o        (stat)
  );

endmodule

// ===== src/dsp_ram.sv =====
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
module dsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dsp_ctrl.sv =====
// Controller state machine: sequences edge loads, depth-first walk,
// relaxation and result readout. Depends on dsp_pkg.
module dsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dsp_pkg::status_t  stat_i,
  output dsp_pkg::cmd_t     cmd_o
);
  import dsp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = !stat_i.out_busy;
        if (!stat_i.out_busy && stat_i.in_valid) begin
          cmd_o.take = 1'b1;
          if (stat_i.run_ok) state_d = S_ROOT;
        end
      end
      S_ROOT: begin
        if (stat_i.root_done) begin
          cmd_o.relax_start = 1'b1;
          state_d = S_RK;
        end else if (stat_i.root_visited) begin
          cmd_o.root_next = 1'b1;
        end else begin
          cmd_o.root_start = 1'b1;
          state_d = S_DREQ;
        end
      end
      S_DREQ: begin
        if (stat_i.edge_end) begin
          cmd_o.fin_push = 1'b1;
          if (stat_i.depth_zero) begin
            cmd_o.root_next = 1'b1;
            state_d = S_ROOT;
          end else begin
            cmd_o.stk_rd = 1'b1;
            state_d = S_DPOP;
          end
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        cmd_o.dfs_step = 1'b1;
        state_d = S_DREQ;
      end
      S_DPOP: begin
        cmd_o.stk_load = 1'b1;
        state_d = S_DREQ;
      end
      S_RK: begin
        if (stat_i.k_zero) begin
          cmd_o.out_start = 1'b1;
          state_d = S_OREQ;
        end else begin
          cmd_o.fin_rd = 1'b1;
          state_d = S_RU;
        end
      end
      S_RU: begin
        if (stat_i.u_reached) begin
          cmd_o.ubest_rd = 1'b1;
          state_d = S_RD;
        end else begin
          state_d = S_RK;
        end
      end
      S_RD: begin
        cmd_o.du_load = 1'b1;
        state_d = S_REQ;
      end
      S_REQ: begin
        if (stat_i.edge_end) begin
          state_d = S_RK;
        end else begin
          cmd_o.edge_rd = 1'b1;
          state_d = S_RCHK;
        end
      end
      S_RCHK: begin
        if (stat_i.relax_match) begin
          cmd_o.vbest_rd = 1'b1;
          state_d = S_RCMP;
        end else begin
          cmd_o.e_next = 1'b1;
          state_d = S_REQ;
        end
      end
      S_RCMP: begin
        cmd_o.relax_upd = 1'b1;
        state_d = S_REQ;
      end
      S_OREQ: begin
        cmd_o.obest_rd = 1'b1;
        state_d = S_OSEND;
      end
      S_OSEND: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d = stat_i.out_last ? S_IDLE : S_OREQ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/dsp_dp.sv =====
// Datapath: edge store, walk stack, finish order and distance RAMs,
// counters, mark bits and the output register. Depends on dsp_pkg, dsp_ram.
module dsp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dsp_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic [1:0]                        opcode_i,
  input  logic [dsp_pkg::NODE_W-1:0]        from_node_i,
  input  logic [dsp_pkg::NODE_W-1:0]        to_node_i,
  input  logic signed [dsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  input  logic [dsp_pkg::NODE_W-1:0]        source_node_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dsp_pkg::NODE_W-1:0]        node_index_o,
  output logic signed [dsp_pkg::DIST_W-1:0] distance_o,
  output logic                              reachable_o,
  output logic                              status_o,
  output logic                              last_o,
  input  dsp_pkg::cmd_t                     cmd_i,
  output dsp_pkg::status_t                  stat_o
);
  import dsp_pkg::*;

  opcode_e                   op;
  logic [CFG_W-1:0]          node_count_q;
  logic [NCNT_W-1:0]         n;
  logic [ECNT_W-1:0]         edge_total_q;
  logic [MAX_NODES-1:0]      visited_q, reached_q;
  logic [NCNT_W-1:0]         r_q, count_q, k_q, k_m1;
  logic [NODE_W-1:0]         depth_q, depth_m1, i_q;
  logic [NODE_W-1:0]         top_u_q, v_q;
  logic [ECNT_W-1:0]         top_e_q;
  logic signed [DIST_W-1:0]  du_q, cand_q, cand;
  logic signed [DIST_W:0]    sum;
  logic                      out_valid_q, out_reach_q, out_status_q, out_last_q;
  logic [NODE_W-1:0]         out_idx_q;
  logic signed [DIST_W-1:0]  out_dist_q;

  logic [EDGE_W-1:0]         edge_rdata;
  logic [NODE_W-1:0]         e_src, e_tgt;
  logic signed [WEIGHT_W-1:0] e_w;
  logic [STK_W-1:0]          stk_rdata;
  logic [NODE_W-1:0]         fin_rdata;
  logic signed [DIST_W-1:0]  best_rdata;

  logic add_ok, run_ok, relax_match, push, improve, out_last_w;
  logic best_we;
  logic [NODE_W-1:0] best_waddr, best_raddr;
  logic signed [DIST_W-1:0] best_wdata;

  assign op = opcode_e'(opcode_i);

  always_comb begin
    if (node_count_q == '0) begin
      n = NCNT_W'(1);
    end else if (node_count_q > CFG_W'(MAX_NODES)) begin
      n = NCNT_W'(MAX_NODES);
    end else begin
      n = NCNT_W'(node_count_q);
    end
  end

  assign {e_src, e_tgt, e_w} = edge_rdata;
  assign k_m1     = k_q - 1'b1;
  assign depth_m1 = depth_q - 1'b1;

  assign add_ok = ({1'b0, from_node_i} < n) && ({1'b0, to_node_i} < n) &&
                  (edge_total_q != ECNT_W'(MAX_EDGES));
  assign run_ok = ({1'b0, source_node_i} < n);
  assign relax_match = (e_src == top_u_q) && ({1'b0, e_tgt} < n);
  assign push = relax_match && !visited_q[e_tgt] &&
                (depth_q < NODE_W'(MAX_NODES - 1));
  assign improve = !reached_q[v_q] || (cand_q < best_rdata);
  assign out_last_w = (({1'b0, i_q} + 1'b1) == n);

  // saturating distance add
  always_comb begin
    sum = {du_q[DIST_W-1], du_q} +
          {{(DIST_W + 1 - WEIGHT_W){e_w[WEIGHT_W-1]}}, e_w};
    if (sum[DIST_W] != sum[DIST_W-1]) begin
      cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      cand = sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      edge_total_q <= '0;
      visited_q    <= '0;
      reached_q    <= '0;
      r_q          <= '0;
      count_q      <= '0;
      k_q          <= '0;
      depth_q      <= '0;
      i_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) node_count_q <= cfg_wdata_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.take) begin
        case (op)
          OP_CLEAR: begin
            edge_total_q <= '0;
            out_valid_q  <= 1'b1;
          end
          OP_ADD: begin
            if (add_ok) edge_total_q <= edge_total_q + 1'b1;
            out_valid_q <= 1'b1;
          end
          OP_RUN: begin
            if (run_ok) begin
              visited_q <= '0;
              reached_q <= MAX_NODES'(1) << source_node_i;
              r_q     <= '0;
              count_q <= '0;
            end else begin
              out_valid_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.root_next) r_q <= r_q + 1'b1;
      if (cmd_i.root_start) begin
        visited_q[r_q[NODE_W-1:0]] <= 1'b1;
        depth_q <= '0;
      end
      if (cmd_i.fin_push) count_q <= count_q + 1'b1;
      if (cmd_i.stk_rd) depth_q <= depth_m1;
      if (cmd_i.dfs_step && push) begin
        depth_q <= depth_q + 1'b1;
        visited_q[e_tgt] <= 1'b1;
      end
      if (cmd_i.relax_start) k_q <= count_q;
      if (cmd_i.fin_rd) k_q <= k_m1;
      if (cmd_i.relax_upd && improve) reached_q[v_q] <= 1'b1;
      if (cmd_i.out_start) i_q <= '0;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        i_q <= i_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      out_idx_q    <= '0;
      out_dist_q   <= '0;
      out_reach_q  <= 1'b0;
      out_status_q <= (op == OP_ADD) ? !add_ok : (op == OP_RUN);
      out_last_q   <= 1'b1;
    end
    if (cmd_i.root_start) begin
      top_u_q <= r_q[NODE_W-1:0];
      top_e_q <= '0;
    end
    if (cmd_i.dfs_step) begin
      if (push) begin
        top_u_q <= e_tgt;
        top_e_q <= '0;
      end else begin
        top_e_q <= top_e_q + 1'b1;
      end
    end
    if (cmd_i.stk_load) {top_u_q, top_e_q} <= stk_rdata;
    if (cmd_i.ubest_rd) top_u_q <= fin_rdata;
    if (cmd_i.du_load) begin
      du_q    <= best_rdata;
      top_e_q <= '0;
    end
    if (cmd_i.e_next) top_e_q <= top_e_q + 1'b1;
    if (cmd_i.vbest_rd) begin
      v_q    <= e_tgt;
      cand_q <= cand;
    end
    if (cmd_i.relax_upd) begin
      // self loop updates the working distance of the current node
      if (improve && (v_q == top_u_q)) du_q <= cand_q;
      top_e_q <= top_e_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      out_idx_q    <= i_q;
      out_dist_q   <= reached_q[i_q] ? best_rdata : '0;
      out_reach_q  <= reached_q[i_q];
      out_status_q <= 1'b0;
      out_last_q   <= out_last_w;
    end
  end

  dsp_ram #(.Width(EDGE_W), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.take && (op == OP_ADD) && add_ok),
    .waddr_i (edge_total_q[EDGE_AW-1:0]),
    .wdata_i ({from_node_i, to_node_i, edge_weight_i}),
    .re_i    (cmd_i.edge_rd),
    .raddr_i (top_e_q[EDGE_AW-1:0]),
    .rdata_o (edge_rdata)
  );

  dsp_ram #(.Width(STK_W), .Depth(MAX_NODES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.dfs_step && push),
    .waddr_i (depth_q),
    .wdata_i ({top_u_q, top_e_q + 1'b1}),
    .re_i    (cmd_i.stk_rd),
    .raddr_i (depth_m1),
    .rdata_o (stk_rdata)
  );

  dsp_ram #(.Width(NODE_W), .Depth(MAX_NODES)) u_fin_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fin_push),
    .waddr_i (count_q[NODE_W-1:0]),
    .wdata_i (top_u_q),
    .re_i    (cmd_i.fin_rd),
    .raddr_i (k_m1[NODE_W-1:0]),
    .rdata_o (fin_rdata)
  );

  assign best_we = (cmd_i.take && (op == OP_RUN) && run_ok) ||
                   (cmd_i.relax_upd && improve);
  assign best_waddr = cmd_i.relax_upd ? v_q : source_node_i;
  assign best_wdata = cmd_i.relax_upd ? cand_q : '0;

  always_comb begin
    if (cmd_i.ubest_rd) begin
      best_raddr = fin_rdata;
    end else if (cmd_i.vbest_rd) begin
      best_raddr = e_tgt;
    end else begin
      best_raddr = i_q;
    end
  end

  dsp_ram #(.Width(DIST_W), .Depth(MAX_NODES)) u_best_ram (
    .clk_i   (clk_i),
    .we_i    (best_we),
    .waddr_i (best_waddr),
    .wdata_i (best_wdata),
    .re_i    (cmd_i.ubest_rd || cmd_i.vbest_rd || cmd_i.obest_rd),
    .raddr_i (best_raddr),
    .rdata_o (best_rdata)
  );

  assign stat_o.in_valid     = in_valid_i;
  assign stat_o.out_busy     = out_valid_q;
  assign stat_o.run_ok       = (op == OP_RUN) && run_ok;
  assign stat_o.root_done    = (r_q == n);
  assign stat_o.root_visited = visited_q[r_q[NODE_W-1:0]];
  assign stat_o.edge_end     = (top_e_q == edge_total_q);
  assign stat_o.depth_zero   = (depth_q == '0);
  assign stat_o.k_zero       = (k_q == '0);
  assign stat_o.u_reached    = reached_q[fin_rdata];
  assign stat_o.relax_match  = relax_match;
  assign stat_o.out_last     = out_last_w;

  assign out_valid_o  = out_valid_q;
  assign node_index_o = out_idx_q;
  assign distance_o   = out_dist_q;
  assign reachable_o  = out_reach_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NCNT_W'(MAX_NODES))
    else $error("finish count overflow");

  a_edge_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_total_q <= ECNT_W'(MAX_EDGES))
    else $error("edge count overflow");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !out_valid_q)
    else $error("result loaded over pending transaction");

  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.dfs_step && push) |=> visited_q[top_u_q])
    else $error("pushed node not marked visited");

endmodule
